// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the lexer RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on aclk outside reset.
`define ELX_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on aclk outside reset.
`define ELX_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/elx_pkg.sv =====
// Shared types, codes and byte classes for the expression token lexer.
package elx_pkg;

    localparam int OFFSET_BITS_DEF = 24;
    localparam int LINE_BITS_DEF   = 16;
    localparam int LEN_BITS        = 16;
    localparam int KIND_BITS       = 4;
    localparam int FIFO_DEPTH      = 4;

    typedef enum logic [KIND_BITS-1:0] {
        KIND_IDENT    = 4'd0,
        KIND_INT      = 4'd1,
        KIND_PLUS     = 4'd2,
        KIND_PLUS2    = 4'd3,
        KIND_MINUS    = 4'd4,
        KIND_MINUS2   = 4'd5,
        KIND_STAR     = 4'd6,
        KIND_STAR2    = 4'd7,
        KIND_SLASH    = 4'd8,
        KIND_SLASH2   = 4'd9,
        KIND_LPAREN   = 4'd10,
        KIND_RPAREN   = 4'd11,
        KIND_SEMI     = 4'd12,
        KIND_EOF      = 4'd13,
        KIND_ERROR    = 4'd14
    } token_kind_t;

    typedef enum logic [6:0] {
        MODE_IDLE   = 7'b0000001,
        MODE_IDENT  = 7'b0000010,
        MODE_NUMBER = 7'b0000100,
        MODE_PLUS   = 7'b0001000,
        MODE_MINUS  = 7'b0010000,
        MODE_STAR   = 7'b0100000,
        MODE_SLASH  = 7'b1000000
    } scan_mode_t;

    // Which of the two token slots the scanner fills this cycle.
    typedef struct packed {
        logic tok_a;
        logic tok_b;
    } tok_push_t;

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_UNDER  = 8'h5F;

    function automatic logic is_dec_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_word_lead(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A))
            || (c == CH_UNDER);
    endfunction

endpackage

// ===== rtl/core/elx_scan.sv =====
// Scanner: mode register, position counters and token formation per byte.
module elx_scan #(
    parameter int OFFSET_BITS = elx_pkg::OFFSET_BITS_DEF,
    parameter int LINE_BITS   = elx_pkg::LINE_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_fire,
    input  logic [7:0]            char_byte,
    input  logic                  end_of_input,
    output elx_pkg::tok_push_t    push,
    output logic [elx_pkg::KIND_BITS+OFFSET_BITS+elx_pkg::LEN_BITS+LINE_BITS:0] tok_a_data,
    output logic [elx_pkg::KIND_BITS+OFFSET_BITS+elx_pkg::LEN_BITS+LINE_BITS:0] tok_b_data
);
    import elx_pkg::*;
    `include "assert_macros.svh"

    localparam logic [LINE_BITS-1:0] LINE_MAX = {LINE_BITS{1'b1}};
    localparam logic [LEN_BITS-1:0]  LEN_MAX  = {LEN_BITS{1'b1}};
    localparam logic [LINE_BITS-1:0] LINE_ONE = LINE_BITS'(1);

    scan_mode_t             mode_reg, mode_next;
    logic [OFFSET_BITS-1:0] off_reg, off_next;
    logic [LINE_BITS-1:0]   line_reg, line_next;
    logic [OFFSET_BITS-1:0] pstart_reg, pstart_next;
    logic [LINE_BITS-1:0]   pline_reg, pline_next;
    logic [LEN_BITS-1:0]    plen_reg, plen_next;

    token_kind_t            a_kind, b_kind, flush_kind;
    logic [OFFSET_BITS-1:0] a_off, b_off, off_inc;
    logic [LEN_BITS-1:0]    a_len, b_len, flush_len;
    logic [LINE_BITS-1:0]   a_line, b_line;
    logic                   a_last;
    logic                   pending, word_mode, op_mode, more;
    logic [7:0]             op_char;

    // Decode the pending mode
    always_comb begin
        case (mode_reg)
            MODE_IDENT:  begin flush_kind = KIND_IDENT; op_char = CH_SLASH; end
            MODE_NUMBER: begin flush_kind = KIND_INT;   op_char = CH_SLASH; end
            MODE_PLUS:   begin flush_kind = KIND_PLUS;  op_char = CH_PLUS;  end
            MODE_MINUS:  begin flush_kind = KIND_MINUS; op_char = CH_MINUS; end
            MODE_STAR:   begin flush_kind = KIND_STAR;  op_char = CH_STAR;  end
            MODE_SLASH:  begin flush_kind = KIND_SLASH; op_char = CH_SLASH; end
            default:     begin flush_kind = KIND_IDENT; op_char = CH_SLASH; end
        endcase
    end

    assign pending   = (mode_reg != MODE_IDLE);
    assign word_mode = (mode_reg == MODE_IDENT) || (mode_reg == MODE_NUMBER);
    assign op_mode   = pending && !word_mode;
    assign more      = (mode_reg == MODE_IDENT)
                       ? (is_word_lead(char_byte) || is_dec_digit(char_byte))
                       : is_dec_digit(char_byte);
    assign flush_len = word_mode ? plen_reg : LEN_BITS'(1);
    assign off_inc   = off_reg + OFFSET_BITS'(1);

    // Step the scanner on each accepted byte
    always_comb begin
        mode_next   = mode_reg;
        off_next    = off_reg;
        line_next   = line_reg;
        pstart_next = pstart_reg;
        pline_next  = pline_reg;
        plen_next   = plen_reg;
        push        = '0;
        a_kind      = flush_kind;
        a_off       = pstart_reg;
        a_len       = flush_len;
        a_line      = pline_reg;
        a_last      = 1'b0;
        b_kind      = KIND_ERROR;
        b_off       = off_reg;
        b_len       = LEN_BITS'(1);
        b_line      = line_reg;
        if (in_fire) begin
            if (end_of_input) begin
                // flush, emit EOF, return to reset values
                push.tok_a  = pending;
                push.tok_b  = 1'b1;
                b_kind      = KIND_EOF;
                b_len       = '0;
                mode_next   = MODE_IDLE;
                off_next    = '0;
                line_next   = LINE_ONE;
                pstart_next = '0;
                pline_next  = LINE_ONE;
                plen_next   = '0;
            end else if (word_mode && more) begin
                // extend the pending word
                if (plen_reg != LEN_MAX) begin
                    plen_next = plen_reg + LEN_BITS'(1);
                end
                off_next = off_inc;
            end else if (op_mode && (char_byte == op_char)) begin
                // form the doubled operator
                push.tok_a = 1'b1;
                a_kind     = token_kind_t'(flush_kind + KIND_BITS'(1));
                a_len      = LEN_BITS'(2);
                a_last     = 1'b1;
                mode_next  = MODE_IDLE;
                off_next   = off_inc;
            end else begin
                push.tok_a = pending;
                mode_next  = MODE_IDLE;
                off_next   = off_inc;
                if (char_byte inside {CH_SPACE, CH_TAB, CH_CR, CH_LF}) begin
                    if ((char_byte == CH_LF) && (line_reg != LINE_MAX)) begin
                        line_next = line_reg + LINE_BITS'(1);
                    end
                end else if (is_dec_digit(char_byte) || is_word_lead(char_byte)
                             || (char_byte inside {CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH}))
                begin
                    pstart_next = off_reg;
                    pline_next  = line_reg;
                    plen_next   = LEN_BITS'(1);
                    if (is_dec_digit(char_byte)) begin
                        mode_next = MODE_NUMBER;
                    end else if (is_word_lead(char_byte)) begin
                        mode_next = MODE_IDENT;
                    end else begin
                        case (char_byte)
                            CH_PLUS:  mode_next = MODE_PLUS;
                            CH_MINUS: mode_next = MODE_MINUS;
                            CH_STAR:  mode_next = MODE_STAR;
                            default:  mode_next = MODE_SLASH;
                        endcase
                    end
                end else begin
                    push.tok_b = 1'b1;
                    case (char_byte)
                        CH_LPAREN: b_kind = KIND_LPAREN;
                        CH_RPAREN: b_kind = KIND_RPAREN;
                        CH_SEMI:   b_kind = KIND_SEMI;
                        default:   b_kind = KIND_ERROR;
                    endcase
                end
                a_last = !push.tok_b;
            end
        end
    end

    assign tok_a_data = {a_kind, a_off, a_len, a_line, a_last};
    assign tok_b_data = {b_kind, b_off, b_len, b_line, 1'b1};

    // Hold state across bytes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_IDLE;
            off_reg    <= '0;
            line_reg   <= LINE_ONE;
            pstart_reg <= '0;
            pline_reg  <= LINE_ONE;
            plen_reg   <= '0;
        end else begin
            mode_reg   <= mode_next;
            off_reg    <= off_next;
            line_reg   <= line_next;
            pstart_reg <= pstart_next;
            pline_reg  <= pline_next;
            plen_reg   <= plen_next;
        end
    end

    `ELX_ASSERT_IMPL(a_flush_needs_pending, push.tok_a, mode_reg != MODE_IDLE,
                     "flush without pending token")
    `ELX_ASSERT_NEXT(a_eof_restarts, in_fire && end_of_input,
                     (mode_reg == MODE_IDLE) && (off_reg == '0) && (line_reg == LINE_ONE),
                     "state not restarted after end item")

endmodule

// ===== rtl/core/elx_tok_fifo.sv =====
// Token queue: takes up to two tokens per cycle, hands out one per cycle while m_ready is high.
module elx_tok_fifo #(
    parameter int DATA_W = 61
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  elx_pkg::tok_push_t push,
    input  logic [DATA_W-1:0]  a_data,
    input  logic [DATA_W-1:0]  b_data,
    output logic               room_two,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [DATA_W-1:0]  m_data
);
    import elx_pkg::*;
    `include "assert_macros.svh"

    localparam int PTR_BITS = $clog2(FIFO_DEPTH);
    localparam int CNT_BITS = $clog2(FIFO_DEPTH + 1);

    logic [DATA_W-1:0]   slot_reg [FIFO_DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next, b_ptr;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg, count_next;
    logic [1:0]          push_n;
    logic                pop;

    assign push_n   = {1'b0, push.tok_a} + {1'b0, push.tok_b};
    assign pop      = m_valid && m_ready;
    assign b_ptr    = push.tok_a ? (wr_ptr_reg + PTR_BITS'(1)) : wr_ptr_reg;
    assign m_valid  = (count_reg != '0);
    assign m_data   = slot_reg[rd_ptr_reg];
    assign room_two = (count_reg <= CNT_BITS'(FIFO_DEPTH - 2));

    // Advance pointers and occupancy
    always_comb begin
        wr_ptr_next = wr_ptr_reg + PTR_BITS'(push_n);
        rd_ptr_next = rd_ptr_reg + PTR_BITS'(pop);
        count_next  = count_reg + CNT_BITS'(push_n) - CNT_BITS'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store pushed tokens in order
    always_ff @(posedge aclk) begin
        if (push.tok_a) begin
            slot_reg[wr_ptr_reg] <= a_data;
        end
        if (push.tok_b) begin
            slot_reg[b_ptr] <= b_data;
        end
    end

    `ELX_ASSERT_IMPL(a_count_bound, 1'b1, count_reg <= CNT_BITS'(FIFO_DEPTH), "token queue count out of range")
    `ELX_ASSERT_IMPL(a_no_overflow, push.tok_a || push.tok_b, count_reg <= CNT_BITS'(FIFO_DEPTH - 2), "push into token queue without room")

endmodule

// ===== rtl/core/expression_token_lexer.sv =====
// Top level of the expression token lexer: scanner plus token queue.
//
// Input channel (s_*): one source byte per transfer in s_char_byte; a transfer
// with s_end_of_input high ends the source (s_char_byte is then ignored),
// flushes any pending token, emits EOF and restarts offsets and lines.
// Result channel (m_*): one token per transfer with kind, start offset,
// length and starting line; m_last_of_run marks the last token caused by
// an input transfer. Bytes that only extend or open a token give none.
// The token queue registers a token on the byte that ends it; m_* presents
// it from the queue. Throughput: one byte per cycle while s_ready is high;
// the scanner state updates on every accepted byte. Results leave one per
// cycle while m_ready is high, from a four-entry token queue, so a byte that
// causes two tokens yields two transfers on m_*. s_ready is high while the
// queue has room for two tokens, so a stalled receiver can hold it low.
// Reset (aresetn low, synchronous) empties the queue, returns to idle mode,
// offset 0, line 1. No clearing pass is needed.
module expression_token_lexer #(
    parameter int OFFSET_BITS = elx_pkg::OFFSET_BITS_DEF,
    parameter int LINE_BITS   = elx_pkg::LINE_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [7:0]                    s_char_byte,
    input  logic                          s_end_of_input,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [elx_pkg::KIND_BITS-1:0] m_token_kind,
    output logic [OFFSET_BITS-1:0]        m_token_offset,
    output logic [elx_pkg::LEN_BITS-1:0]  m_token_length,
    output logic [LINE_BITS-1:0]          m_token_line,
    output logic                          m_last_of_run
);
    import elx_pkg::*;

    localparam int TOK_W    = KIND_BITS + OFFSET_BITS + LEN_BITS + LINE_BITS + 1;
    localparam int LINE_LO  = 1;
    localparam int LEN_LO   = LINE_LO + LINE_BITS;
    localparam int OFF_LO   = LEN_LO + LEN_BITS;
    localparam int KIND_LO  = OFF_LO + OFFSET_BITS;

    tok_push_t          push;
    logic [TOK_W-1:0]   tok_a_data, tok_b_data, m_data;
    logic               in_fire;

    assign in_fire = s_valid && s_ready;

    elx_scan #(
        .OFFSET_BITS (OFFSET_BITS),
        .LINE_BITS   (LINE_BITS)
    ) u_scan (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_fire      (in_fire),
        .char_byte    (s_char_byte),
        .end_of_input (s_end_of_input),
        .push         (push),
        .tok_a_data   (tok_a_data),
        .tok_b_data   (tok_b_data)
    );

    elx_tok_fifo #(
        .DATA_W (TOK_W)
    ) u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .a_data   (tok_a_data),
        .b_data   (tok_b_data),
        .room_two (s_ready),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

    // Split the queued token into its fields
    assign m_token_kind   = m_data[KIND_LO +: KIND_BITS];
    assign m_token_offset = m_data[OFF_LO +: OFFSET_BITS];
    assign m_token_length = m_data[LEN_LO +: LEN_BITS];
    assign m_token_line   = m_data[LINE_LO +: LINE_BITS];
    assign m_last_of_run  = m_data[0];

endmodule
